// File: hw/rtl/sfr_pkg.sv
// Package for the framed serial byte receiver.
// Holds framing bytes, prefix length, result kind codes and the register reset value.
// No dependencies.
package sfr_pkg;

    localparam logic [2:0]  PREFIX_COUNT     = 3'd7;
    localparam logic [7:0]  PRE_BYTE         = 8'hAA;
    localparam logic [7:0]  START_BYTE       = 8'hAB;
    localparam logic [15:0] MAX_LENGTH_RESET = 16'd256;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_BAD  = 2'd2
    } kind_t;

endpackage

// File: hw/rtl/sync_frame_receiver.sv
// Framed serial byte receiver: prefix hunt, length, payload, checksum.
// Depends on sfr_pkg for framing constants and result kind codes.
//
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+-------------------------------------
// byte     | in        | byte_valid / byte_stall    | rx_byte
// result   | out       | result_valid / result_stall| out_kind, out_byte, byte_index,
//          |           |                            | frame_length, last
// cfg      | in        | cfg_valid / cfg_ready      | max_length
//
// An accepted item sits in the input register while the parser logic works on it;
// when the parser steps, any result it produces is loaded into the result register
// and offered from there. One item is taken every cycle unless byte_stall holds the
// input; the running sum is a 16-bit adder and the byte counter a 17-bit one in that path.
// Reset (rst_n, asynchronous, active low) puts the parser in the prefix hunt with all
// counters and the sum cleared and max_length at 256.
// byte_stall rises only while an item sits in the input register and the result
// register holds an item that the consumer has stalled.
module sync_frame_receiver
    import sfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  rx_byte,

    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  out_kind,
    output logic [7:0]  out_byte,
    output logic [15:0] byte_index,
    output logic [15:0] frame_length,
    output logic        last,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] max_length
);

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_START = 3'd1,
        PH_LEN   = 3'd2,
        PH_DATA  = 3'd3,
        PH_CHECK = 3'd4
    } phase_t;

    // Configuration
    logic [15:0] max_length_reg;

    // Input register
    logic        byte_valid_reg;
    logic [7:0]  byte_reg;

    // Parser state
    phase_t      phase_reg,        phase_next;
    logic [2:0]  prefix_count_reg, prefix_count_next;
    logic [15:0] length_reg,       length_next;
    logic [15:0] byte_count_reg,   byte_count_next;
    logic [15:0] running_sum_reg,  running_sum_next;
    logic [7:0]  sum_high_reg,     sum_high_next;
    logic        second_half_reg,  second_half_next;

    // Result register
    logic        result_valid_reg, result_valid_next;
    kind_t       kind_reg,         kind_next;
    logic [7:0]  out_byte_reg,     out_byte_next;
    logic [15:0] byte_index_reg,   byte_index_next;
    logic [15:0] frame_length_reg, frame_length_next;
    logic        last_reg,         last_next;

    logic        out_free;
    logic        step;
    logic        emit;
    logic [2:0]  prefix_inc;
    logic [16:0] count_inc;

    // The result register can take a new item when empty or being drained.
    assign out_free   = !result_valid_reg || !result_stall;
    assign step       = byte_valid_reg && out_free;
    assign byte_stall = byte_valid_reg && !out_free;
    assign cfg_ready  = 1'b1;

    assign prefix_inc = prefix_count_reg + 3'd1;
    assign count_inc  = {1'b0, byte_count_reg} + 17'd1;

    // Parser step for the byte in the input register
    always_comb
    begin
        phase_next        = phase_reg;
        prefix_count_next = prefix_count_reg;
        length_next       = length_reg;
        byte_count_next   = byte_count_reg;
        running_sum_next  = running_sum_reg;
        sum_high_next     = sum_high_reg;
        second_half_next  = second_half_reg;
        emit              = 1'b0;
        kind_next         = KIND_DATA;
        out_byte_next     = 8'd0;
        byte_index_next   = byte_count_reg;
        frame_length_next = length_reg;
        last_next         = 1'b0;

        unique case (phase_reg)
            PH_START:
            begin
                if (byte_reg == START_BYTE)
                begin
                    phase_next       = PH_LEN;
                    second_half_next = 1'b0;
                    length_next      = 16'd0;
                end
                else
                begin
                    phase_next        = PH_HUNT;
                    prefix_count_next = 3'd0;
                end
            end

            PH_LEN:
            begin
                if (!second_half_reg)
                begin
                    length_next      = {byte_reg, 8'd0};
                    second_half_next = 1'b1;
                end
                else
                begin
                    length_next      = {length_reg[15:8], byte_reg};
                    second_half_next = 1'b0;
                    byte_count_next  = 16'd0;
                    running_sum_next = 16'd0;
                    // Drop over-length frames without a result
                    if (length_next > max_length_reg)
                    begin
                        phase_next        = PH_HUNT;
                        prefix_count_next = 3'd0;
                    end
                    else if (length_next == 16'd0)
                    begin
                        phase_next = PH_CHECK;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
            end

            PH_DATA:
            begin
                emit             = 1'b1;
                out_byte_next    = byte_reg;
                running_sum_next = running_sum_reg + {8'd0, byte_reg};
                byte_count_next  = count_inc[15:0];
                if (count_inc >= {1'b0, length_reg})
                begin
                    phase_next       = PH_CHECK;
                    second_half_next = 1'b0;
                end
            end

            PH_CHECK:
            begin
                if (!second_half_reg)
                begin
                    sum_high_next    = byte_reg;
                    second_half_next = 1'b1;
                end
                else
                begin
                    second_half_next  = 1'b0;
                    emit              = 1'b1;
                    last_next         = 1'b1;
                    kind_next         = ({sum_high_reg, byte_reg} == running_sum_reg)
                                        ? KIND_GOOD : KIND_BAD;
                    phase_next        = PH_HUNT;
                    prefix_count_next = 3'd0;
                end
            end

            default:
            begin
                // Prefix hunt: count consecutive preamble bytes
                phase_next        = PH_HUNT;
                prefix_count_next = (byte_reg == PRE_BYTE) ? prefix_inc : 3'd0;
                if (prefix_count_next >= PREFIX_COUNT)
                begin
                    phase_next = PH_START;
                end
            end
        endcase
    end

    assign result_valid_next = out_free ? (step && emit) : result_valid_reg;

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg   <= MAX_LENGTH_RESET;
            byte_valid_reg   <= 1'b0;
            phase_reg        <= PH_HUNT;
            prefix_count_reg <= 3'd0;
            length_reg       <= 16'd0;
            byte_count_reg   <= 16'd0;
            running_sum_reg  <= 16'd0;
            sum_high_reg     <= 8'd0;
            second_half_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                max_length_reg <= max_length;
            end
            if (!byte_stall)
            begin
                byte_valid_reg <= byte_valid;
            end
            if (step)
            begin
                phase_reg        <= phase_next;
                prefix_count_reg <= prefix_count_next;
                length_reg       <= length_next;
                byte_count_reg   <= byte_count_next;
                running_sum_reg  <= running_sum_next;
                sum_high_reg     <= sum_high_next;
                second_half_reg  <= second_half_next;
            end
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (!byte_stall && byte_valid)
        begin
            byte_reg <= rx_byte;
        end
        if (step && emit)
        begin
            kind_reg         <= kind_next;
            out_byte_reg     <= out_byte_next;
            byte_index_reg   <= byte_index_next;
            frame_length_reg <= frame_length_next;
            last_reg         <= last_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign out_kind     = kind_reg;
    assign out_byte     = out_byte_reg;
    assign byte_index   = byte_index_reg;
    assign frame_length = frame_length_reg;
    assign last         = last_reg;

`ifndef SYNTHESIS
    // The input side only stalls behind a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> (result_valid && result_stall))
        else $error("input stalled without a blocked result");

    // In the payload phase the counter stays below a nonzero length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (length_reg != 16'd0 && byte_count_reg < length_reg))
        else $error("payload counter out of range");

    // The hunt never holds a full prefix count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HUNT) |-> (prefix_count_reg < PREFIX_COUNT))
        else $error("prefix count overflow in hunt");

    // A stalled result is not replaced by a new one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> !$past(step))
        else $error("parser advanced while result stalled");
`endif

endmodule
